>>> hdl/iirl_pkg.sv
// Package for the indexed insert/remove list core.
// Holds the field widths, command and status codes, and the request, result and
// cell-control struct types. It depends on nothing else.
package iirl_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned IDX_W         = 7;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     command;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic                     empty_res;
    } t_rsp;

    // Shift control handed from the command decode to the storage row.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

>>> hdl/iirl_cells.sv
// Row of storage cells for the indexed insert/remove list.
// Each cell compares its own position with the index and shifts in parallel.
// Depends on iirl_pkg.
module iirl_cells
    import iirl_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    output logic signed [DATA_W-1:0] o_rd_data
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned KW = (CW > IDX_W) ? CW : IDX_W;

    logic signed [DATA_W-1:0] r_e [DEPTH];
    logic signed [DATA_W-1:0] n_e [DEPTH];
    logic [KW-1:0]            idx_ext;

    assign idx_ext = KW'(i_ctrl.idx);

    // The word at the index, taken before this cycle's shift.
    always_comb begin
        o_rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (KW'(i) == idx_ext) begin
                o_rd_data = r_e[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [KW-1:0] POS = KW'(g);

        if (g == 0) begin : g_first
            always_comb begin
                n_e[g] = r_e[g];
                if (i_ctrl.ins && (POS == idx_ext)) begin
                    n_e[g] = i_ctrl.value;
                end else if (i_ctrl.rem && (POS >= idx_ext) && (DEPTH > 1)) begin
                    n_e[g] = r_e[g + 1];
                end
            end
        end else if (g == DEPTH - 1) begin : g_last
            always_comb begin
                n_e[g] = r_e[g];
                if (i_ctrl.ins && (POS == idx_ext)) begin
                    n_e[g] = i_ctrl.value;
                end else if (i_ctrl.ins && (POS > idx_ext)) begin
                    n_e[g] = r_e[g - 1];
                end
            end
        end else begin : g_mid
            always_comb begin
                n_e[g] = r_e[g];
                if (i_ctrl.ins && (POS == idx_ext)) begin
                    n_e[g] = i_ctrl.value;
                end else if (i_ctrl.ins && (POS > idx_ext)) begin
                    n_e[g] = r_e[g - 1];
                end else if (i_ctrl.rem && (POS >= idx_ext)) begin
                    n_e[g] = r_e[g + 1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_e[g] <= n_e[g];
        end
    end

endmodule

>>> hdl/indexed_insert_remove_list_core.sv
// Indexed insert/remove list core: a bounded ordered list of signed 32-bit words.
// A request is first held in the request register, then the command is executed
// against the cell row into the result register. Throughput, set by the single-pass
// cell shift, is one request per cycle while i_out_stall does not hold a waiting result.
// Reset (i_rst_n low, synchronous) empties the list and drops both pipeline registers;
// the stored words keep whatever they held and are never seen before being written.
module indexed_insert_remove_list_core
    import iirl_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned KW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

    // Request register and result register.
    logic          r_req_valid;
    t_req          r_req;
    logic          r_out_valid;
    t_rsp          r_out;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                     adv;
    logic                     fire;
    logic [KW-1:0]            idx_ext;
    logic [KW-1:0]            cnt_ext;
    t_cell_ctrl               ctrl;
    t_rsp                     rsp;
    logic signed [DATA_W-1:0] rd_data;

    // The result register can take a new result when it is empty or being drained.
    // The request register executes whenever it holds a request and can advance.
    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_req_valid && adv;
    assign o_in_stall = r_req_valid && !adv;

    assign idx_ext = KW'(r_req.index);
    assign cnt_ext = KW'(r_count);

    // Command decode. Index range is checked before the full condition on insert.
    // The unused command code leaves everything as is and reports success.
    always_comb begin
        ctrl.ins   = 1'b0;
        ctrl.rem   = 1'b0;
        ctrl.idx   = r_req.index;
        ctrl.value = r_req.value;
        n_count    = r_count;
        rsp.status = ST_OK;
        rsp.data   = '0;
        case (r_req.command)
            CMD_INSERT: begin
                if (idx_ext > cnt_ext) begin
                    rsp.status = ST_RANGE;
                end else if (cnt_ext >= DEPTH_K) begin
                    rsp.status = ST_FULL;
                end else begin
                    ctrl.ins = fire;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (idx_ext >= cnt_ext) begin
                    rsp.status = ST_RANGE;
                end else begin
                    ctrl.rem = fire;
                    rsp.data = rd_data;
                    n_count  = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (idx_ext >= cnt_ext) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.data = rd_data;
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
        rsp.count     = COUNT_W'(n_count);
        rsp.empty_res = (n_count == '0);
    end

    // The cell row shifts only on an executing insert or remove.
    iirl_cells #(
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_req_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_req_valid;
            end
            if (fire) begin
                r_count <= n_count;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (fire) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // The list never holds more than DEPTH entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_count) <= DEPTH_K)
        else $error("entry count above depth");

    // A shown result always matches the live count, since nothing executes
    // while the result waits.
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.empty_res == (r_count == '0)))
        else $error("empty flag disagrees with entry count");

    // A list-full status is only reported when the list is at depth.
    a_full_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status == ST_FULL)) |-> (KW'(r_count) == DEPTH_K))
        else $error("full status reported below depth");

endmodule
